/* hdl/pap_pkg.sv */
// Shared types and codes for the preferential attachment picker.
`timescale 1ns / 1ps

package pap_pkg;

    // Node index width (6-bit node count register)
    localparam int IDX_W = 6;
    // Degree and total width
    localparam int DEG_W = 16;
    // Cumulative degree over up to 63 nodes
    localparam int CUM_W = DEG_W + IDX_W;
    // Draw width (Q0.16)
    localparam int DRAW_W = 16;

    // Configuration register indexes
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_SEED_COUNT = 1'b1;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_STARTED  = 3'd0,
        STAT_FIRST    = 3'd1,
        STAT_REJECTED = 3'd2,
        STAT_ATTACHED = 3'd3,
        STAT_IGNORED  = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEED   = 8'b0000_0010,
        ST_MUL    = 8'b0000_0100,
        ST_SCAN   = 8'b0000_1000,
        ST_UPD_RA = 8'b0001_0000,
        ST_UPD_WA = 8'b0010_0000,
        ST_UPD_WB = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

endpackage

/* hdl/preferential_attachment_picker_core.sv */
// Degree-weighted roulette picker that grows a scale-free graph, linking each new node to a pair of distinct nodes.
// Draw beat: the scan reads one degree entry per cycle and checks each entry as its
// registered read returns; an attach then read-modify-writes the picked degrees.
// Start beat: one seed entry written per cycle. Ignored draws go straight to the result.
// One beat is in flight at a time; the next is accepted once its result is loaded.
// Reset (synchronous, active low) clears control state only.
`timescale 1ns / 1ps

module preferential_attachment_picker_core #(
    parameter int MAX_NODES = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [pap_pkg::IDX_W-1:0]  cfg_wdata,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [15:0] draw
    input  logic                       s_tuser,   // [0] command
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // [4:0] new_node, [9:5] neighbour_a,
                                                  // [14:10] neighbour_b, [15] finished
    output logic [2:0]                 m_tuser    // [2:0] status
);

    import pap_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    // Degree memory
    logic [DEG_W-1:0] deg_mem [MAX_NODES];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [DEG_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [DEG_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            deg_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= deg_mem[mem_raddr];
        end
    end

    // Registers
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    node_cnt_reg, seed_cnt_reg;
    logic [DRAW_W-1:0]   draw_reg, draw_next;
    logic [31:0]         target_reg, target_next;
    logic [DEG_W-1:0]    total_reg, total_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic                await_reg, await_next;
    logic [IDX_W-1:0]    first_reg, first_next;
    logic                run_reg, run_next;
    logic [IDX_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [CUM_W-1:0]    cum_reg, cum_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    logic [IDX_W-1:0]    seed_idx_reg, seed_idx_next;
    status_t             res_stat_reg, res_stat_next;
    logic [IDX_W-1:0]    res_nn_reg, res_nn_next;
    logic [IDX_W-1:0]    res_na_reg, res_na_next;
    logic [IDX_W-1:0]    res_nb_reg, res_nb_next;
    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_data_reg, m_data_next;
    logic [2:0]          m_user_reg, m_user_next;

    // Effective register values and scan limit
    logic [IDX_W-1:0] eff_seed, eff_nodes, limit;
    logic             finished;
    logic [CUM_W-1:0] cum_sum;
    logic             hit;
    logic [IDX_W-1:0] p_found;
    logic             scan_end;

    always_comb begin
        eff_seed = seed_cnt_reg;
        if (eff_seed < IDX_W'(2)) begin
            eff_seed = IDX_W'(2);
        end
        if (32'(eff_seed) > MAX_NODES) begin
            eff_seed = IDX_W'(MAX_NODES);
        end
        eff_nodes = node_cnt_reg;
        if (32'(eff_nodes) > MAX_NODES) begin
            eff_nodes = IDX_W'(MAX_NODES);
        end
        limit = cur_reg;
        if (32'(limit) > MAX_NODES) begin
            limit = IDX_W'(MAX_NODES);
        end
    end

    assign finished = run_reg && (cur_reg >= eff_nodes);

    // Scan compare: 65536 * cumulative >= draw * total
    assign cum_sum = cum_reg + CUM_W'(rd_data_reg);
    assign hit     = chk_vld_reg && ({cum_sum, 16'b0} >= {{(CUM_W - 16){1'b0}}, target_reg});
    assign scan_end = !chk_vld_reg && (issue_idx_reg >= limit);

    always_comb begin
        if (hit) begin
            p_found = chk_idx_reg;
        end else if (limit == '0) begin
            p_found = '0;
        end else begin
            p_found = limit - IDX_W'(1);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        draw_next      = draw_reg;
        target_next    = target_reg;
        total_next     = total_reg;
        cur_next       = cur_reg;
        await_next     = await_reg;
        first_next     = first_reg;
        run_next       = run_reg;
        issue_idx_next = issue_idx_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        cum_next       = cum_reg;
        pick_next      = pick_reg;
        seed_idx_next  = seed_idx_reg;
        res_stat_next  = res_stat_reg;
        res_nn_next    = res_nn_reg;
        res_na_next    = res_na_reg;
        res_nb_next    = res_nb_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        // result register drains
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_na_next = '0;
                    res_nb_next = '0;
                    if (s_tuser == CMD_START) begin
                        total_next    = DEG_W'(eff_seed) * (DEG_W'(eff_seed) - DEG_W'(1));
                        cur_next      = eff_seed;
                        await_next    = 1'b0;
                        first_next    = '0;
                        run_next      = 1'b1;
                        seed_idx_next = '0;
                        res_stat_next = STAT_STARTED;
                        res_nn_next   = (eff_seed >= eff_nodes) ? '0 : eff_seed;
                        state_next    = ST_SEED;
                    end else if (!run_reg || finished) begin
                        res_stat_next = STAT_IGNORED;
                        res_nn_next   = '0;
                        state_next    = ST_DONE;
                    end else begin
                        draw_next  = s_tdata;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SEED: begin
                // cur_reg holds the effective seed count here
                mem_we        = 1'b1;
                mem_waddr     = AW'(seed_idx_reg);
                mem_wdata     = DEG_W'(cur_reg - IDX_W'(1));
                seed_idx_next = seed_idx_reg + IDX_W'(1);
                if (seed_idx_reg == cur_reg - IDX_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                target_next    = 32'(draw_reg) * 32'(total_reg);
                issue_idx_next = '0;
                chk_vld_next   = 1'b0;
                cum_next       = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                // issue one read per cycle, check the entry read last cycle
                if (issue_idx_reg < limit) begin
                    mem_re         = 1'b1;
                    mem_raddr      = AW'(issue_idx_reg);
                    chk_vld_next   = 1'b1;
                    chk_idx_next   = issue_idx_reg;
                    issue_idx_next = issue_idx_reg + IDX_W'(1);
                end else begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg) begin
                    cum_next = cum_sum;
                end
                if (hit || scan_end) begin
                    res_nn_next = cur_reg;
                    if (!await_reg) begin
                        first_next    = p_found;
                        await_next    = 1'b1;
                        res_stat_next = STAT_FIRST;
                        res_na_next   = p_found;
                        res_nb_next   = '0;
                        state_next    = ST_DONE;
                    end else if (p_found == first_reg) begin
                        res_stat_next = STAT_REJECTED;
                        res_na_next   = first_reg;
                        res_nb_next   = p_found;
                        state_next    = ST_DONE;
                    end else begin
                        pick_next     = p_found;
                        res_stat_next = STAT_ATTACHED;
                        res_na_next   = first_reg;
                        res_nb_next   = p_found;
                        state_next    = ST_UPD_RA;
                    end
                end
            end
            ST_UPD_RA: begin
                // read first choice; the new node's entry never collides with it
                mem_re    = 1'b1;
                mem_raddr = AW'(first_reg);
                if (32'(cur_reg) < MAX_NODES) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(cur_reg);
                    mem_wdata = DEG_W'(2);
                end
                state_next = ST_UPD_WA;
            end
            ST_UPD_WA: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(first_reg);
                mem_wdata  = rd_data_reg + DEG_W'(1);
                mem_re     = 1'b1;
                mem_raddr  = AW'(pick_reg);
                state_next = ST_UPD_WB;
            end
            ST_UPD_WB: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(pick_reg);
                mem_wdata  = rd_data_reg + DEG_W'(1);
                total_next = total_reg + DEG_W'(4);
                cur_next   = cur_reg + IDX_W'(1);
                await_next = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // load the result beat once the output slot is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_stat_reg;
                    m_data_next  = {finished, res_nb_reg[4:0], res_na_reg[4:0],
                                    res_nn_reg[4:0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            node_cnt_reg <= IDX_W'(30);
            seed_cnt_reg <= IDX_W'(5);
            total_reg    <= '0;
            cur_reg      <= '0;
            await_reg    <= 1'b0;
            first_reg    <= '0;
            run_reg      <= 1'b0;
            chk_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            cur_reg     <= cur_next;
            await_reg   <= await_next;
            first_reg   <= first_next;
            run_reg     <= run_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_NODE_COUNT: node_cnt_reg <= cfg_wdata;
                    REG_SEED_COUNT: seed_cnt_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        draw_reg      <= draw_next;
        target_reg    <= target_next;
        issue_idx_reg <= issue_idx_next;
        chk_idx_reg   <= chk_idx_next;
        cum_reg       <= cum_next;
        pick_reg      <= pick_next;
        seed_idx_reg  <= seed_idx_next;
        res_stat_reg  <= res_stat_next;
        res_nn_reg    <= res_nn_next;
        res_na_reg    <= res_na_next;
        res_nb_reg    <= res_nb_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the preferential attachment picker core.
`timescale 1ns / 1ps

module tb_top;
    import pap_pkg::*;

    localparam int MAX_NODES    = 32;
    localparam int TARGET_BEATS = 1500;
    localparam int CALM_BEATS   = 200;      // final stretch runs with no idling
    localparam int IDLE_WAIT    = MAX_NODES + 16;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_CYCLES = 1000000;

    // One expected result beat
    typedef struct packed {
        status_t    status;
        logic [4:0] new_node;
        logic [4:0] nbr_a;
        logic [4:0] nbr_b;
        logic       finished;
    } attach_rec_t;

    // Graph growth predictor and result checker
    class attach_scoreboard;
        logic [5:0]  node_reg = 6'd30;
        logic [5:0]  seed_reg = 6'd5;
        logic [15:0] degree [MAX_NODES] = '{default: '0};
        logic [15:0] total = '0;
        int unsigned cur = 0;
        int unsigned first = 0;
        bit          awaiting = 1'b0;
        bit          running = 1'b0;
        int          errors = 0;
        attach_rec_t expected_q [$];

        function void set_reg(logic idx, logic [5:0] val);
            if (idx == REG_NODE_COUNT) node_reg = val;
            else seed_reg = val;
        endfunction

        function bit graph_done();
            int unsigned n;
            n = node_reg;
            if (n > MAX_NODES) n = MAX_NODES;
            return running && (cur >= n);
        endfunction

        // Apply one accepted beat; returns 0 when the beat is ignored
        function bit predict_growth(logic cmd, logic [15:0] draw);
            attach_rec_t      r;
            int unsigned      s, lim, p, i;
            longint unsigned  target, cum;
            r = '0;
            if (cmd == CMD_START) begin
                // seed clique, seed count clamped to 2..MAX_NODES
                s = seed_reg;
                if (s < 2) s = 2;
                if (s > MAX_NODES) s = MAX_NODES;
                foreach (degree[k]) degree[k] = (k < s) ? 16'(s - 1) : 16'd0;
                total    = 16'(s * (s - 1));
                cur      = s;
                awaiting = 1'b0;
                first    = 0;
                running  = 1'b1;
                r.status = STAT_STARTED;
                r.new_node = graph_done() ? 5'd0 : 5'(cur);
            end else if (!running || graph_done()) begin
                r.status = STAT_IGNORED;
            end else begin
                // roulette scan: first node whose cumulative degree covers the draw
                lim = (cur > MAX_NODES) ? MAX_NODES : cur;
                p = (lim == 0) ? 0 : lim - 1;
                target = 64'(draw) * 64'(total);
                cum = 0;
                for (i = 0; i < lim; i++) begin
                    cum += 64'(degree[i]);
                    if ((cum << 16) >= target) begin
                        p = i;
                        break;
                    end
                end
                r.new_node = 5'(cur);
                if (!awaiting) begin
                    first    = p;
                    awaiting = 1'b1;
                    r.status = STAT_FIRST;
                    r.nbr_a  = 5'(p);
                end else if (p == first) begin
                    r.status = STAT_REJECTED;
                    r.nbr_a  = 5'(first);
                    r.nbr_b  = 5'(p);
                end else begin
                    degree[first] = degree[first] + 16'd1;
                    degree[p]     = degree[p] + 16'd1;
                    if (cur < MAX_NODES) degree[cur] = 16'd2;
                    total    = total + 16'd4;
                    r.status = STAT_ATTACHED;
                    r.nbr_a  = 5'(first);
                    r.nbr_b  = 5'(p);
                    cur      = (cur + 1) & 6'h3F;
                    awaiting = 1'b0;
                end
            end
            r.finished = graph_done();
            expected_q.push_back(r);
            return r.status != STAT_IGNORED;
        endfunction

        function void field_check(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [2:0] st, logic [15:0] d);
            attach_rec_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d data %h",
                         $time, st, d);
                return;
            end
            e = expected_q.pop_front();
            field_check("status", e.status, st);
            field_check("new_node", e.new_node, d[4:0]);
            field_check("neighbour_a", e.nbr_a, d[9:5]);
            field_check("neighbour_b", e.nbr_b, d[14:10]);
            field_check("finished", e.finished, d[15]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [5:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;      // [15:0] draw
    logic        s_tuser;      // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [4:0] new_node, [9:5] neighbour_a, [14:10] neighbour_b,
                               // [15] finished
    logic [2:0]  m_tuser;      // [2:0] status

    attach_scoreboard sb = new;

    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          long_hold_req = 1'b0;
    int          beats_sent = 0;
    int          cycle_count = 0;
    logic [15:0] last_draw = '0;

    preferential_attachment_picker_core #(
        .MAX_NODES(MAX_NODES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall bursts plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result monitor
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        end
    end

    // Offer one beat, optionally after an idle burst, and wait for acceptance
    task automatic send_beat(logic cmd, logic [15:0] draw);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= draw;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (sb.predict_growth(cmd, draw)) beats_sent++;
    endtask

    // Drop valid and wait until every result is back and the core is quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [5:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Draw value: mostly random, with extremes and repeats that force rejections
    function automatic logic [15:0] next_draw();
        logic [15:0] d;
        case ($urandom_range(0, 9))
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            2, 3:    d = last_draw;
            default: d = 16'($urandom);
        endcase
        last_draw = d;
        return d;
    endfunction

    // Stimulus
    initial begin
        int phase;
        int budget;
        logic [5:0] val;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_NODE_COUNT;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tuser   = CMD_START;
        s_tdata   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // draws before any start are ignored
        send_beat(CMD_DRAW, 16'hFFFF);
        send_beat(CMD_DRAW, 16'h0000);

        // reset settings: first pick, repeat rejected, attach
        send_beat(CMD_START, 16'h1234);
        send_beat(CMD_DRAW, 16'h0000);
        send_beat(CMD_DRAW, 16'h0000);
        send_beat(CMD_DRAW, 16'hFFFF);
        send_beat(CMD_DRAW, 16'h8000);
        send_beat(CMD_DRAW, 16'h8000);
        send_beat(CMD_DRAW, 16'h0001);
        send_beat(CMD_DRAW, 16'hAAAA);
        send_beat(CMD_DRAW, 16'h5555);
        settle();

        // smallest graph: one attach finishes it, then draws are ignored
        write_reg(REG_NODE_COUNT, 6'd3);
        write_reg(REG_SEED_COUNT, 6'd2);
        send_beat(CMD_START, 16'h0000);
        send_beat(CMD_DRAW, 16'h0000);
        send_beat(CMD_DRAW, 16'hFFFF);
        send_beat(CMD_DRAW, 16'h7FFF);
        settle();

        // out-of-range low settings: seed clamps up, graph finished at once
        write_reg(REG_NODE_COUNT, 6'd0);
        write_reg(REG_SEED_COUNT, 6'd0);
        send_beat(CMD_START, 16'hFFFF);
        send_beat(CMD_DRAW, 16'h4000);
        settle();

        // out-of-range high settings: both clamp to the node limit
        write_reg(REG_NODE_COUNT, 6'd63);
        write_reg(REG_SEED_COUNT, 6'd63);
        send_beat(CMD_START, 16'h0000);
        send_beat(CMD_DRAW, 16'hC000);
        settle();

        write_reg(REG_NODE_COUNT, 6'd32);
        write_reg(REG_SEED_COUNT, 6'd1);
        send_beat(CMD_START, 16'h0000);

        // Random phases: settings change only with the core idle
        phase = 0;
        while (beats_sent < TARGET_BEATS) begin
            settle();
            gaps_on   = (beats_sent < TARGET_BEATS - CALM_BEATS) && ($urandom_range(0, 3) != 0);
            stalls_on = (beats_sent < TARGET_BEATS - CALM_BEATS) && ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 7))
                    0:       val = 6'($urandom_range(0, 63));
                    1:       val = 6'd3;
                    2:       val = 6'd32;
                    default: val = 6'($urandom_range(3, 32));
                endcase
                write_reg(REG_NODE_COUNT, val);
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 7))
                    0:       val = 6'($urandom_range(0, 63));
                    1:       val = 6'd2;
                    default: val = 6'($urandom_range(2, 8));
                endcase
                write_reg(REG_SEED_COUNT, val);
            end

            // receiver holds off once while the sender keeps offering
            if (phase == 2) long_hold_req = 1'b1;

            if (!sb.running || sb.graph_done() || $urandom_range(0, 4) != 0)
                send_beat(CMD_START, 16'($urandom));

            // well-formed growth, with the odd restart mid-graph
            budget = $urandom_range(8, 90);
            while (budget > 0 && !sb.graph_done()) begin
                if ($urandom_range(0, 49) == 0) send_beat(CMD_START, 16'($urandom));
                else send_beat(CMD_DRAW, next_draw());
                budget--;
            end

            // stray draws, ignored once the graph is finished
            repeat ($urandom_range(0, 2)) send_beat(CMD_DRAW, 16'($urandom));
            phase++;
        end

        settle();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
